// ===== design/dhf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dhf_pkg
// Shared types and constants for the depth hole fill and rigid transform.
// ----------------------------------------------------------------------------
package dhf_pkg;

    localparam int MAX_WIDTH       = 1024;
    localparam int MAX_HEIGHT      = 512;
    localparam int MAX_HALF_WINDOW = 7;

    localparam int COL_W   = 10;
    localparam int ROW_W   = 9;
    localparam int ADDR_W  = COL_W + ROW_W;
    localparam int PT_W    = 16;
    localparam int ENTRY_W = 3 * PT_W + 1;
    localparam int REG_W   = 48;
    localparam int HW_W    = 3;
    localparam int FW_W    = 11;
    localparam int FH_W    = 10;
    localparam int CNT_W   = 8;
    localparam int SUM_W   = 24;
    localparam int ACC_W   = 35;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 64;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_QUERY,
        CMD_OUTSIDE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t               kind;
        logic [COL_W-1:0]        col;
        logic [ROW_W-1:0]        row;
        logic signed [PT_W-1:0]  x;
        logic signed [PT_W-1:0]  y;
        logic signed [PT_W-1:0]  z;
        logic                    present;
    } cmd_t;

    typedef enum logic [2:0] {
        REG_TRANSFORM_READY,
        REG_ROTATION_ROW_X,
        REG_ROTATION_ROW_Y,
        REG_ROTATION_ROW_Z,
        REG_TRANSLATION_XYZ,
        REG_HALF_WINDOW,
        REG_FRAME_WIDTH,
        REG_FRAME_HEIGHT
    } cfg_index_t;

    typedef struct packed {
        logic              ready;
        logic [REG_W-1:0]  rot_x;
        logic [REG_W-1:0]  rot_y;
        logic [REG_W-1:0]  rot_z;
        logic [REG_W-1:0]  trans;
        logic [HW_W-1:0]   half_window;
        logic [FW_W-1:0]   width_lim;
        logic [FH_W-1:0]   height_lim;
    } xform_cfg_t;

endpackage
`default_nettype wire

// ===== design/dhf_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dhf_front
// Accepts input transactions, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module dhf_front
    import dhf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // col[9:0], row[18:10], x[34:19], y[50:35], z[66:51], present[67]
    input  wire logic [IN_TDATA_W-1:0] s_tdata,
    // op[0]
    input  wire logic                  s_tuser,
    input  wire logic [FW_W-1:0]       width_lim,
    input  wire logic [FH_W-1:0]       height_lim,
    output logic                       cmd_valid,
    output cmd_t                       cmd,
    input  wire logic                  cmd_pop
);

    cmd_t               queue_mem [QDEPTH];
    cmd_t               in_cmd;
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W:0]    count_reg;
    logic [QPTR_W:0]    count_next;
    logic               push;
    logic               in_frame;

    assign in_frame = ({1'b0, s_tdata[9:0]} < width_lim) &&
                      ({1'b0, s_tdata[18:10]} < height_lim);

    always_comb
    begin
        in_cmd.col     = s_tdata[9:0];
        in_cmd.row     = s_tdata[18:10];
        in_cmd.x       = s_tdata[34:19];
        in_cmd.y       = s_tdata[50:35];
        in_cmd.z       = s_tdata[66:51];
        in_cmd.present = s_tdata[67];
        if (!s_tuser)
            in_cmd.kind = CMD_LOAD;
        else if (in_frame)
            in_cmd.kind = CMD_QUERY;
        else
            in_cmd.kind = CMD_OUTSIDE;
    end

    assign s_tready  = (count_reg != (QPTR_W+1)'(QDEPTH));
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !cmd_pop)
            count_next = count_reg + 1'b1;
        else if (!push && cmd_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            queue_mem[wr_ptr_reg] <= in_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (cmd_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/dhf_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dhf_back
// Point store, window walk, mean divider and serial rigid transform.
// ----------------------------------------------------------------------------
module dhf_back
    import dhf_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cmd_valid,
    input  cmd_t                        cmd,
    output logic                        cmd_pop,
    input  xform_cfg_t                  cfg,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // x[15:0], y[31:16], z[47:32], result_valid[48], neighbors_used[56:49]
    output logic [OUT_TDATA_W-1:0]      m_tdata
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CENTER,
        S_WALK,
        S_DRAIN,
        S_PREP,
        S_DIV,
        S_SETP,
        S_MUL,
        S_FIN,
        S_OUT
    } state_t;

    state_t                  state_reg;
    logic [ENTRY_W-1:0]      mem [MAX_WIDTH*MAX_HEIGHT];
    logic [ENTRY_W-1:0]      rdata_reg;
    logic                    mem_we;
    logic                    mem_re;
    logic [ADDR_W-1:0]       mem_addr;

    logic [COL_W-1:0]        col_reg;
    logic [ROW_W-1:0]        row_reg;
    logic signed [11:0]      cw_reg;
    logic signed [10:0]      rw_reg;
    logic signed [11:0]      c_lo;
    logic signed [11:0]      c_hi;
    logic signed [10:0]      r_lo;
    logic signed [10:0]      r_hi;
    logic                    in_bounds;
    logic                    rvld_reg;

    logic signed [SUM_W-1:0] sum_reg [3];
    logic [CNT_W-1:0]        cnt_reg;
    logic                    found_reg;

    logic [SUM_W-1:0]        quo_reg [3];
    logic [CNT_W:0]          rem_reg [3];
    logic                    neg_reg [3];
    logic [CNT_W:0]          den_reg;
    logic [4:0]              div_cnt_reg;
    logic [SUM_W-1:0]        quo_next [3];
    logic [CNT_W:0]          rem_next [3];
    logic [SUM_W-1:0]        mag [3];

    logic signed [PT_W-1:0]  p_reg [3];
    logic [1:0]              ax_reg;
    logic [1:0]              j_reg;
    logic [REG_W-1:0]        rot [3];
    logic signed [PT_W-1:0]  coef;
    logic signed [31:0]      prod_reg;
    logic [1:0]              prod_ax_reg;
    logic                    prod_vld_reg;
    logic signed [ACC_W-1:0] acc_reg [3];
    logic signed [PT_W-1:0]  res [3];

    logic                    out_valid_reg;
    logic [OUT_TDATA_W-1:0]  out_data_reg;
    logic                    out_free;
    logic                    out_load;
    logic                    use_xform;

    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign out_load = out_free &&
                      ((state_reg == S_IDLE && cmd_valid && cmd.kind != CMD_LOAD &&
                        cmd.kind != CMD_QUERY) || (state_reg == S_OUT));

    assign c_lo = signed'({2'b00, col_reg}) - signed'({9'd0, cfg.half_window});
    assign c_hi = signed'({2'b00, col_reg}) + signed'({9'd0, cfg.half_window});
    assign r_lo = signed'({2'b00, row_reg}) - signed'({8'd0, cfg.half_window});
    assign r_hi = signed'({2'b00, row_reg}) + signed'({8'd0, cfg.half_window});

    assign in_bounds = !cw_reg[11] && (cw_reg < signed'({1'b0, cfg.width_lim})) &&
                       !rw_reg[10] && (rw_reg < signed'({1'b0, cfg.height_lim}));

    assign rot[0] = cfg.rot_x;
    assign rot[1] = cfg.rot_y;
    assign rot[2] = cfg.rot_z;
    assign coef   = rot[ax_reg][16*j_reg +: 16];

    always_comb
    begin
        cmd_pop  = 1'b0;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        mem_addr = {cmd.row, cmd.col};
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.kind)
                        CMD_LOAD:
                        begin
                            mem_we  = 1'b1;
                            cmd_pop = 1'b1;
                        end
                        CMD_QUERY:
                        begin
                            mem_re  = 1'b1;
                            cmd_pop = 1'b1;
                        end
                        default:
                            cmd_pop = out_free;
                    endcase
                end
            end
            S_WALK:
            begin
                mem_re   = in_bounds;
                mem_addr = {rw_reg[ROW_W-1:0], cw_reg[COL_W-1:0]};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= {cmd.present, cmd.z, cmd.y, cmd.x};
        if (mem_re)
            rdata_reg <= mem[mem_addr];
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            logic [CNT_W+1:0] rem_sh;
            rem_sh = {rem_reg[k], quo_reg[k][SUM_W-1]};
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next[k] = (CNT_W+1)'(rem_sh - {1'b0, den_reg});
                quo_next[k] = {quo_reg[k][SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = rem_sh[CNT_W:0];
                quo_next[k] = {quo_reg[k][SUM_W-2:0], 1'b0};
            end
            mag[k] = sum_reg[k][SUM_W-1] ? SUM_W'(-sum_reg[k]) : sum_reg[k];
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            logic signed [ACC_W-15:0] r;
            r = (ACC_W-14)'(acc_reg[k] >>> 14);
            if (r > 21'sd32767)
                res[k] = 16'sh7FFF;
            else if (r < -21'sd32768)
                res[k] = 16'sh8000;
            else
                res[k] = r[PT_W-1:0];
        end
    end

    assign use_xform = found_reg && cfg.ready;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && cmd_valid && cmd.kind == CMD_QUERY)
        begin
            col_reg <= cmd.col;
            row_reg <= cmd.row;
        end
        prod_reg    <= coef * p_reg[j_reg];
        prod_ax_reg <= ax_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            rvld_reg      <= 1'b0;
            prod_vld_reg  <= 1'b0;
            cw_reg        <= '0;
            rw_reg        <= '0;
            cnt_reg       <= '0;
            found_reg     <= 1'b0;
            den_reg       <= '0;
            div_cnt_reg   <= '0;
            ax_reg        <= '0;
            j_reg         <= '0;
            for (int k = 0; k < 3; k++)
            begin
                sum_reg[k] <= '0;
                quo_reg[k] <= '0;
                rem_reg[k] <= '0;
                neg_reg[k] <= 1'b0;
                p_reg[k]   <= '0;
                acc_reg[k] <= '0;
            end
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            rvld_reg     <= (state_reg == S_WALK) && in_bounds;
            prod_vld_reg <= (state_reg == S_MUL);

            if (rvld_reg && rdata_reg[ENTRY_W-1])
            begin
                cnt_reg <= cnt_reg + 1'b1;
                for (int k = 0; k < 3; k++)
                    sum_reg[k] <= sum_reg[k] +
                        SUM_W'(signed'(rdata_reg[16*k +: 16]));
            end

            if (state_reg == S_MUL && ax_reg == 2'd0 && j_reg == 2'd0)
            begin
                for (int k = 0; k < 3; k++)
                    acc_reg[k] <= (ACC_W'(signed'(cfg.trans[16*k +: 16])) <<< 14) +
                                  ACC_W'(8192);
            end
            else if (prod_vld_reg)
                acc_reg[prod_ax_reg] <= acc_reg[prod_ax_reg] + ACC_W'(prod_reg);

            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        if (cmd.kind == CMD_QUERY)
                            state_reg <= S_CENTER;
                        else if (cmd.kind != CMD_LOAD && out_free)
                            out_data_reg <= '0;
                    end
                end
                S_CENTER:
                begin
                    cnt_reg <= '0;
                    for (int k = 0; k < 3; k++)
                        sum_reg[k] <= '0;
                    if (rdata_reg[ENTRY_W-1])
                    begin
                        for (int k = 0; k < 3; k++)
                            p_reg[k] <= rdata_reg[16*k +: 16];
                        found_reg <= 1'b1;
                        ax_reg    <= '0;
                        j_reg     <= '0;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        cw_reg    <= c_lo;
                        rw_reg    <= r_lo;
                        state_reg <= S_WALK;
                    end
                end
                S_WALK:
                begin
                    if (rw_reg == r_hi)
                    begin
                        rw_reg <= r_lo;
                        if (cw_reg == c_hi)
                            state_reg <= S_DRAIN;
                        else
                            cw_reg <= cw_reg + 1'b1;
                    end
                    else
                        rw_reg <= rw_reg + 1'b1;
                end
                S_DRAIN:
                    state_reg <= S_PREP;
                S_PREP:
                begin
                    if (cnt_reg == '0)
                    begin
                        found_reg <= 1'b0;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        den_reg     <= {cnt_reg, 1'b0};
                        div_cnt_reg <= '0;
                        for (int k = 0; k < 3; k++)
                        begin
                            quo_reg[k] <= {mag[k][SUM_W-2:0], 1'b0} + SUM_W'(cnt_reg);
                            rem_reg[k] <= '0;
                            neg_reg[k] <= sum_reg[k][SUM_W-1];
                        end
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        quo_reg[k] <= quo_next[k];
                        rem_reg[k] <= rem_next[k];
                    end
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == 5'(SUM_W - 1))
                        state_reg <= S_SETP;
                end
                S_SETP:
                begin
                    for (int k = 0; k < 3; k++)
                        p_reg[k] <= neg_reg[k] ? PT_W'(-quo_reg[k][PT_W:0])
                                               : quo_reg[k][PT_W-1:0];
                    found_reg <= 1'b1;
                    ax_reg    <= '0;
                    j_reg     <= '0;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    if (j_reg == 2'd2)
                    begin
                        j_reg <= '0;
                        if (ax_reg == 2'd2)
                        begin
                            ax_reg    <= '0;
                            state_reg <= S_FIN;
                        end
                        else
                            ax_reg <= ax_reg + 1'b1;
                    end
                    else
                        j_reg <= j_reg + 1'b1;
                end
                S_FIN:
                    state_reg <= S_OUT;
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_data_reg  <= {7'd0, cnt_reg, use_xform,
                                          use_xform ? res[2] : 16'sd0,
                                          use_xform ? res[1] : 16'sd0,
                                          use_xform ? res[0] : 16'sd0};
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== design/depth_hole_fill_rigid_transform.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// depth_hole_fill_rigid_transform
// Organized point cloud store with neighbourhood hole fill and rigid transform.
// ----------------------------------------------------------------------------
// A load (op 0) writes one pixel's point. A query (op 1) returns one
// transaction, all zero outside the frame; one with its centre point present
// takes a store read plus nine serial multiply-accumulates on one multiplier;
// one with a missing centre walks the (2*half_window+1)^2 window one position
// a cycle, reading the store inside the frame, then, if any neighbour was
// present, runs a radix-2 mean divider and the same multiply-accumulates.
// A four-entry queue separates input acceptance from this processing.
// The store is undefined after reset; query only pixels that were loaded.
// ----------------------------------------------------------------------------
module depth_hole_fill_rigid_transform
    import dhf_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // col[9:0], row[18:10], x[34:19], y[50:35], z[66:51], present[67]
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // op[0]
    input  wire logic                   s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // x[15:0], y[31:16], z[47:32], result_valid[48], neighbors_used[56:49]
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    input  wire logic                   cfg_wen,
    input  wire logic [2:0]             cfg_index,
    input  wire logic [REG_W-1:0]       cfg_wdata
);

    logic              ready_reg;
    logic [REG_W-1:0]  rot_x_reg;
    logic [REG_W-1:0]  rot_y_reg;
    logic [REG_W-1:0]  rot_z_reg;
    logic [REG_W-1:0]  trans_reg;
    logic [HW_W-1:0]   hw_reg;
    logic [FW_W-1:0]   fw_reg;
    logic [FH_W-1:0]   fh_reg;
    xform_cfg_t        cfg;
    logic              cmd_valid;
    cmd_t              cmd;
    logic              cmd_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg <= 1'b0;
            rot_x_reg <= 48'd16384;
            rot_y_reg <= 48'd1073741824;
            rot_z_reg <= 48'd70368744177664;
            trans_reg <= '0;
            hw_reg    <= 3'd2;
            fw_reg    <= 11'd640;
            fh_reg    <= 10'd480;
        end
        else if (cfg_wen)
        begin
            case (cfg_index_t'(cfg_index))
                REG_TRANSFORM_READY: ready_reg <= cfg_wdata[0];
                REG_ROTATION_ROW_X:  rot_x_reg <= cfg_wdata;
                REG_ROTATION_ROW_Y:  rot_y_reg <= cfg_wdata;
                REG_ROTATION_ROW_Z:  rot_z_reg <= cfg_wdata;
                REG_TRANSLATION_XYZ: trans_reg <= cfg_wdata;
                REG_HALF_WINDOW:     hw_reg    <= cfg_wdata[HW_W-1:0];
                REG_FRAME_WIDTH:     fw_reg    <= cfg_wdata[FW_W-1:0];
                REG_FRAME_HEIGHT:    fh_reg    <= cfg_wdata[FH_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        cfg.ready       = ready_reg;
        cfg.rot_x       = rot_x_reg;
        cfg.rot_y       = rot_y_reg;
        cfg.rot_z       = rot_z_reg;
        cfg.trans       = trans_reg;
        cfg.half_window = hw_reg;
        cfg.width_lim   = (fw_reg > FW_W'(MAX_WIDTH)) ? FW_W'(MAX_WIDTH) : fw_reg;
        cfg.height_lim  = (fh_reg > FH_W'(MAX_HEIGHT)) ? FH_W'(MAX_HEIGHT) : fh_reg;
    end

    dhf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .width_lim  (cfg.width_lim),
        .height_lim (cfg.height_lim),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    dhf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .cfg       (cfg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth hole fill and rigid transform testbench
// Loads points into the organised cloud, queries pixels under a range of
// transform, window and frame settings, and checks every result transaction
// against an in-bench predictor of the hole fill, rounding and saturation.
// ----------------------------------------------------------------------------
module testbench;
    import dhf_pkg::*;

    localparam bit OP_LOAD  = 1'b0;
    localparam bit OP_QUERY = 1'b1;
    localparam int DRAIN_CYCLES = 300;
    localparam int STALL_LIMIT  = 5000;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               ok;
        logic [7:0]         used;
    } base_point_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_wen;
    logic [2:0]             cfg_index;
    logic [REG_W-1:0]       cfg_wdata;

    // predictor state
    logic [48:0]   cloud [int];
    logic          xf_ready;
    logic [47:0]   rot [3];
    logic [47:0]   trans;
    int            hw_reg;
    int            fw_reg;
    int            fh_reg;
    base_point_t   pending_points [$];

    int            errors;
    int            burst_left;
    int            hold_cycles;
    int            rx_mode;

    depth_hole_fill_rigid_transform u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint mean_of(longint s, longint n);
        longint mag;
        longint q;
        mag = (s < 0) ? -s : s;
        q = (2 * mag + n) / (2 * n);
        return (s < 0) ? -q : q;
    endfunction

    function automatic logic signed [15:0] rotate_axis(logic [47:0] coefs,
            logic signed [15:0] t, longint px, longint py, longint pz);
        logic signed [15:0] c0;
        logic signed [15:0] c1;
        logic signed [15:0] c2;
        longint acc;
        c0 = coefs[15:0];
        c1 = coefs[31:16];
        c2 = coefs[47:32];
        acc = longint'(t) * 16384 + longint'(c0) * px + longint'(c1) * py
              + longint'(c2) * pz + 8192;
        acc = acc >>> 14;
        if (acc > 32767)
            acc = 32767;
        if (acc < -32768)
            acc = -32768;
        return acc[15:0];
    endfunction

    function automatic int frame_w();
        return (fw_reg < MAX_WIDTH) ? fw_reg : MAX_WIDTH;
    endfunction

    function automatic int frame_h();
        return (fh_reg < MAX_HEIGHT) ? fh_reg : MAX_HEIGHT;
    endfunction

    // true when the query reads only entries loaded since reset
    function automatic bit query_reads_loaded(int col, int row);
        int w;
        int h;
        w = frame_w();
        h = frame_h();
        if (col >= w || row >= h)
            return 1;
        if (!cloud.exists(row * MAX_WIDTH + col))
            return 0;
        if (cloud[row * MAX_WIDTH + col][48])
            return 1;
        for (int c = col - hw_reg; c <= col + hw_reg; c++)
            for (int r = row - hw_reg; r <= row + hw_reg; r++)
                if (c >= 0 && c < w && r >= 0 && r < h
                        && !cloud.exists(r * MAX_WIDTH + c))
                    return 0;
        return 1;
    endfunction

    function automatic base_point_t fill_and_transform(int col, int row);
        base_point_t res;
        longint p [3];
        longint s [3];
        longint cnt;
        logic [48:0] e;
        bit found;
        int w;
        int h;
        res = '{default: '0};
        w = frame_w();
        h = frame_h();
        cnt = 0;
        found = 0;
        s = '{0, 0, 0};
        if (col >= w || row >= h)
            return res;
        e = cloud[row * MAX_WIDTH + col];
        if (e[48])
        begin
            p[0] = longint'($signed(e[15:0]));
            p[1] = longint'($signed(e[31:16]));
            p[2] = longint'($signed(e[47:32]));
            found = 1;
        end
        else
        begin
            for (int c = col - hw_reg; c <= col + hw_reg; c++)
                for (int r = row - hw_reg; r <= row + hw_reg; r++)
                    if (c >= 0 && c < w && r >= 0 && r < h)
                    begin
                        e = cloud[r * MAX_WIDTH + c];
                        if (e[48])
                        begin
                            cnt++;
                            s[0] += longint'($signed(e[15:0]));
                            s[1] += longint'($signed(e[31:16]));
                            s[2] += longint'($signed(e[47:32]));
                        end
                    end
            if (cnt > 0)
            begin
                for (int k = 0; k < 3; k++)
                    p[k] = mean_of(s[k], cnt);
                found = 1;
            end
        end
        res.used = (cnt > 255) ? 8'd255 : cnt[7:0];
        if (found && xf_ready)
        begin
            res.x  = rotate_axis(rot[0], trans[15:0], p[0], p[1], p[2]);
            res.y  = rotate_axis(rot[1], trans[31:16], p[0], p[1], p[2]);
            res.z  = rotate_axis(rot[2], trans[47:32], p[0], p[1], p[2]);
            res.ok = 1'b1;
        end
        return res;
    endfunction

    task automatic write_reg(cfg_index_t idx, logic [47:0] value);
        cfg_wen   = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge clk);
        cfg_wen = 1'b0;
        case (idx)
            REG_TRANSFORM_READY: xf_ready = value[0];
            REG_ROTATION_ROW_X:  rot[0] = value;
            REG_ROTATION_ROW_Y:  rot[1] = value;
            REG_ROTATION_ROW_Z:  rot[2] = value;
            REG_TRANSLATION_XYZ: trans = value;
            REG_HALF_WINDOW:     hw_reg = int'(value[2:0]);
            REG_FRAME_WIDTH:     fw_reg = int'(value[10:0]);
            REG_FRAME_HEIGHT:    fh_reg = int'(value[9:0]);
            default: ;
        endcase
    endtask

    // entered and left at a falling edge
    task automatic send_item(bit op, int col, int row, logic [15:0] x,
            logic [15:0] y, logic [15:0] z, bit present);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 6));
            if (gap > 0)
            begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = int'($urandom_range(1, 20));
        end
        burst_left--;
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = '0;
        s_tdata[67:0] = {present, z, y, x, row[8:0], col[9:0]};
        do
            @(posedge clk);
        while (!s_tready);
        if (op == OP_LOAD)
            cloud[row * MAX_WIDTH + col] = {present, z, y, x};
        else
            pending_points = {pending_points, fill_and_transform(col, row)};
        @(negedge clk);
    endtask

    task automatic load_point(int col, int row);
        send_item(OP_LOAD, col, row, 16'($urandom), 16'($urandom), 16'($urandom),
                  1'($urandom_range(0, 1)));
    endtask

    task automatic query_pixel(int col, int row);
        send_item(OP_QUERY, col, row, 16'($urandom), 16'($urandom), 16'($urandom),
                  1'($urandom_range(0, 1)));
    endtask

    task automatic settle();
        s_tvalid = 1'b0;
        while (pending_points.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic random_query();
        int col;
        int row;
        for (int tries = 0; tries < 8; tries++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                col = int'($urandom_range(0, 1023));
                row = int'($urandom_range(0, 511));
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                col = int'($urandom_range(1016, 1023));
                row = int'($urandom_range(504, 511));
            end
            else
            begin
                col = int'($urandom_range(0, 17));
                row = int'($urandom_range(0, 17));
            end
            if (query_reads_loaded(col, row))
            begin
                query_pixel(col, row);
                return;
            end
        end
        query_pixel(0, 0);
    endtask

    task automatic test_preload();
        for (int r = 0; r < 16; r++)
            for (int c = 0; c < 16; c++)
                load_point(c, r);
        for (int r = 504; r < 512; r++)
            for (int c = 1016; c < 1024; c++)
                load_point(c, r);
        settle();
    endtask

    task automatic test_directed();
        // transform not loaded: counts still reported
        query_pixel(3, 3);
        query_pixel(700, 3);
        settle();
        write_reg(REG_TRANSFORM_READY, 48'd1);
        write_reg(REG_FRAME_WIDTH, 48'd16);
        write_reg(REG_FRAME_HEIGHT, 48'd16);
        send_item(OP_LOAD, 5, 5, 16'h7FFF, 16'h8000, 16'h0000, 1'b1);
        query_pixel(5, 5);
        send_item(OP_LOAD, 6, 6, 16'h8000, 16'h7FFF, 16'hFFFF, 1'b0);
        query_pixel(6, 6);
        query_pixel(15, 15);
        query_pixel(16, 0);
        query_pixel(0, 16);
        settle();
        // saturation in both directions
        write_reg(REG_ROTATION_ROW_X, {16'h7FFF, 16'h7FFF, 16'h7FFF});
        write_reg(REG_ROTATION_ROW_Y, {16'h8000, 16'h8000, 16'h8000});
        write_reg(REG_ROTATION_ROW_Z, {16'h0001, 16'hFFFF, 16'h2000});
        write_reg(REG_TRANSLATION_XYZ, {16'h8000, 16'h7FFF, 16'h0001});
        write_reg(REG_HALF_WINDOW, 48'd7);
        send_item(OP_LOAD, 1, 1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
        query_pixel(1, 1);
        send_item(OP_LOAD, 2, 2, 16'h8000, 16'h8000, 16'h8000, 1'b1);
        query_pixel(2, 2);
        send_item(OP_LOAD, 7, 7, 16'h1234, 16'h8001, 16'h0000, 1'b0);
        query_pixel(7, 7);
        settle();
        write_reg(REG_HALF_WINDOW, 48'd0);
        write_reg(REG_FRAME_WIDTH, 48'd1);
        write_reg(REG_FRAME_HEIGHT, 48'd1);
        query_pixel(0, 0);
        query_pixel(1, 0);
        settle();
        write_reg(REG_FRAME_WIDTH, 48'd1024);
        write_reg(REG_FRAME_HEIGHT, 48'd512);
        write_reg(REG_HALF_WINDOW, 48'd7);
        send_item(OP_LOAD, 1023, 511, 16'hFFFF, 16'h0000, 16'h5555, 1'b0);
        query_pixel(1023, 511);
        query_pixel(1020, 508);
        settle();
    endtask

    task automatic test_random_phases();
        logic [47:0] rv [3];
        for (int ph = 0; ph < 10; ph++)
        begin
            for (int k = 0; k < 3; k++)
                case ($urandom_range(0, 2))
                    0: rv[k] = 48'd16384 << (16 * k);
                    1: rv[k] = 48'({$urandom, $urandom});
                    default: rv[k] = {3{$urandom_range(0, 1) ? 16'h7FFF : 16'h8000}};
                endcase
            write_reg(REG_TRANSFORM_READY, 48'($urandom_range(0, 5) != 0));
            write_reg(REG_ROTATION_ROW_X, rv[0]);
            write_reg(REG_ROTATION_ROW_Y, rv[1]);
            write_reg(REG_ROTATION_ROW_Z, rv[2]);
            write_reg(REG_TRANSLATION_XYZ, 48'({$urandom, $urandom}));
            write_reg(REG_HALF_WINDOW,
                      48'((ph == 0) ? 0 : (ph == 1) ? 7 : int'($urandom_range(0, 7))));
            write_reg(REG_FRAME_WIDTH,
                      48'((ph % 3 == 0) ? 1024 : int'($urandom_range(1, 16))));
            write_reg(REG_FRAME_HEIGHT,
                      48'((ph % 4 == 0) ? 512 : int'($urandom_range(1, 16))));
            for (int n = 0; n < 75; n++)
                if ($urandom_range(0, 9) < 4)
                begin
                    if ($urandom_range(0, 9) == 0)
                        load_point(int'($urandom_range(0, 1023)),
                                   int'($urandom_range(0, 511)));
                    else
                        load_point(int'($urandom_range(0, 15)),
                                   int'($urandom_range(0, 15)));
                end
                else
                    random_query();
            settle();
        end
    endtask

    task automatic test_output_hold_off();
        write_reg(REG_TRANSFORM_READY, 48'd1);
        write_reg(REG_FRAME_WIDTH, 48'd16);
        write_reg(REG_FRAME_HEIGHT, 48'd16);
        write_reg(REG_HALF_WINDOW, 48'd1);
        hold_cycles = 800;
        for (int n = 0; n < 40; n++)
            random_query();
        settle();
    endtask

    // result receiver
    initial
    begin
        int mode_timer;
        m_tready   = 1'b0;
        rx_mode    = 0;
        mode_timer = 0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_tready = 1'b0;
                hold_cycles--;
            end
            else
            begin
                case (rx_mode)
                    0: m_tready = 1'b1;
                    1: m_tready = 1'($urandom_range(0, 1));
                    default: m_tready = ($urandom_range(0, 3) == 0);
                endcase
                if (++mode_timer >= 150)
                begin
                    mode_timer = 0;
                    rx_mode = int'($urandom_range(0, 2));
                end
            end
        end
    end

    // result checker
    initial
    begin
        base_point_t exp_pt;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (pending_points.size() == 0)
                begin
                    $error("unexpected transaction: tdata %h", m_tdata);
                    errors++;
                end
                else
                begin
                    exp_pt = pending_points.pop_front();
                    if (m_tdata[15:0] !== exp_pt.x)
                    begin
                        $error("base_x expected %0d got %0d", exp_pt.x, $signed(m_tdata[15:0]));
                        errors++;
                    end
                    if (m_tdata[31:16] !== exp_pt.y)
                    begin
                        $error("base_y expected %0d got %0d", exp_pt.y, $signed(m_tdata[31:16]));
                        errors++;
                    end
                    if (m_tdata[47:32] !== exp_pt.z)
                    begin
                        $error("base_z expected %0d got %0d", exp_pt.z, $signed(m_tdata[47:32]));
                        errors++;
                    end
                    if (m_tdata[48] !== exp_pt.ok)
                    begin
                        $error("result_valid expected %0d got %0d", exp_pt.ok, m_tdata[48]);
                        errors++;
                    end
                    if (m_tdata[56:49] !== exp_pt.used)
                    begin
                        $error("neighbors_used expected %0d got %0d", exp_pt.used,
                               m_tdata[56:49]);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else if (s_tvalid || pending_points.size() != 0)
                idle_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        cfg_wen     = 1'b0;
        cfg_index   = '0;
        cfg_wdata   = '0;
        errors      = 0;
        burst_left  = 0;
        hold_cycles = 0;
        xf_ready    = 1'b0;
        rot[0]      = 48'd16384;
        rot[1]      = 48'd1073741824;
        rot[2]      = 48'd70368744177664;
        trans       = '0;
        hw_reg      = 2;
        fw_reg      = 640;
        fh_reg      = 480;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_preload();
        test_directed();
        test_random_phases();
        test_output_hold_off();

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
